// File: rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam logic [7:0]  BROKEN_HOPS  = 8'hFF;
    localparam logic [7:0]  RSSI_UNKNOWN = 8'h81;
    localparam int          RSSI_GAIN    = 10;
    localparam logic [7:0]  HOP_JUMP     = 8'd2;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_UPSERT = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;
    localparam logic [1:0] CMD_RSSI   = 2'd3;

    localparam logic [1:0] CFG_NBR_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_ROUTE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_SETTLE        = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_NBR_OLD,
        ST_NBR_NEW,
        ST_WRITE,
        ST_SWEEP_CHK,
        ST_SWEEP_PROP,
        ST_NBR_SET,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic clr_idx;    // index counter to zero
        logic inc_idx;    // index counter + 1
        logic scan_step;  // evaluate slot at index for lookup/upsert search
        logic decide;     // evaluate upsert rules on found slot
        logic nbr_old;    // nbr search for old next hop (result to rssi_old)
        logic nbr_new;    // nbr search for offered via (result to rssi_new)
        logic commit;     // perform upsert write
        logic sweep_chk;  // sweep: inspect slot idx
        logic sweep_prop; // sweep: propagate break to routes via broken dest
        logic nbr_set;    // set rssi
        logic out_load;   // latch result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic       last_idx;    // index at last route slot
        logic       need_break;  // sweep slot just broken, propagate
        logic       need_rssi;   // upsert needs rssi compare
    } t_sts;

endpackage

// File: rtl/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Command sequencer of the route table.
// ----------------------------------------------------------------------------
module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_cmd,
    input  logic       i_out_free,
    input  t_sts       i_sts,
    output logic       o_busy,
    output t_ctl       o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.clr_idx = 1'b1;
                    unique case (i_cmd)
                        CMD_SWEEP: n_state = ST_SWEEP_CHK;
                        CMD_RSSI:  n_state = ST_NBR_SET;
                        default:   n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                o_ctl.scan_step = 1'b1;
                o_ctl.inc_idx   = 1'b1;
                if (i_sts.last_idx) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_ctl.decide  = 1'b1;
                o_ctl.clr_idx = 1'b1;
                if (i_sts.need_rssi) n_state = ST_NBR_OLD;
                else                 n_state = ST_WRITE;
            end
            ST_NBR_OLD: begin
                o_ctl.nbr_old = 1'b1;
                n_state = ST_NBR_NEW;
            end
            ST_NBR_NEW: begin
                o_ctl.nbr_new = 1'b1;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_ctl.commit = 1'b1;
                n_state = ST_DONE;
            end
            ST_SWEEP_CHK: begin
                o_ctl.sweep_chk = 1'b1;
                if (i_sts.need_break) begin
                    n_state = ST_SWEEP_PROP;
                end else begin
                    o_ctl.inc_idx = 1'b1;
                    if (i_sts.last_idx) n_state = ST_DONE;
                end
            end
            ST_SWEEP_PROP: begin
                o_ctl.sweep_prop = 1'b1;
                o_ctl.inc_idx    = 1'b1;
                if (i_sts.last_idx) n_state = ST_DONE;
                else                n_state = ST_SWEEP_CHK;
            end
            ST_NBR_SET: begin
                o_ctl.nbr_set = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/dvrt_datapath.sv
// ----------------------------------------------------------------------------
// dvrt_datapath
// Route slots, neighbor table and per-command evaluation logic.
// ----------------------------------------------------------------------------
module dvrt_datapath
    import dvrt_pkg::*;
#(
    parameter int ROUTES    = 16,
    parameter int NEIGHBORS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_dest,
    input  logic [15:0] i_via_hop,
    input  logic [7:0]  i_hops,
    input  logic [31:0] i_seq,
    input  logic [15:0] i_neighbor_addr,
    input  logic [7:0]  i_rssi,
    output t_sts        o_sts,
    output logic [59:0] o_result
);

    localparam int RW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int NW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam logic [RW-1:0] LAST_R = RW'(ROUTES - 1);
    localparam logic [NW-1:0] LAST_N = NW'(NEIGHBORS - 1);

    logic [23:0] r_nbr_to, r_rte_to, r_settle;

    logic [15:0] r_dest  [ROUTES];
    logic [15:0] r_nh    [ROUTES];
    logic [7:0]  r_hp    [ROUTES];
    logic [31:0] r_sq    [ROUTES];
    logic [31:0] r_st    [ROUTES];
    logic        r_mark  [ROUTES];
    logic [15:0] r_naddr [NEIGHBORS];
    logic [7:0]  r_nrssi [NEIGHBORS];
    logic [NW-1:0] r_victim;

    logic [1:0]  r_cmd;
    logic [31:0] r_now, r_sqi;
    logic [15:0] r_d, r_via, r_na;
    logic [7:0]  r_h, r_rs;

    logic [RW-1:0] r_idx;
    logic          r_hit, r_empty_ok, r_hit_exp;
    logic [RW-1:0] r_hit_idx, r_empty_idx, r_old_idx;
    logic [31:0]   r_best_age;

    // upsert decision
    typedef enum logic [1:0] {W_NONE, W_FULL, W_STAMP, W_RSSI} t_wkind;
    t_wkind        r_wk;
    logic [RW-1:0] r_wslot;
    logic          r_oce, r_rce;
    logic signed [8:0] r_rs_old, r_rs_new;

    logic [15:0] r_gone;

    logic [59:0] r_res;

    // slot at index
    logic [31:0] age_i;
    logic        dir_i, exp_i;
    always_comb begin
        age_i = r_now - r_st[r_idx];
        dir_i = (r_dest[r_idx] == r_nh[r_idx]) && (r_hp[r_idx] == 8'd1);
        exp_i = age_i > {8'd0, (dir_i ? r_nbr_to : r_rte_to)};
    end

    // found slot
    logic [31:0] age_h;
    logic        dir_h, exp_h;
    always_comb begin
        age_h = r_now - r_st[r_hit_idx];
        dir_h = (r_dest[r_hit_idx] == r_nh[r_hit_idx]) && (r_hp[r_hit_idx] == 8'd1);
        exp_h = age_h > {8'd0, (dir_h ? r_nbr_to : r_rte_to)};
    end

    // neighbor lookup
    logic [15:0] nq;
    logic [7:0]  nres;
    always_comb begin
        nq = i_ctl.nbr_old ? r_nh[r_hit_idx] : r_via;
        nres = RSSI_UNKNOWN;
        if (nq != 16'd0) begin
            for (int k = NEIGHBORS - 1; k >= 0; k--) begin
                if (r_naddr[k] == nq) nres = r_nrssi[k];
            end
        end
    end

    // neighbor set slot
    logic [NW-1:0] nslot;
    logic          nmatch, nempty;
    always_comb begin
        nslot  = r_victim;
        nmatch = 1'b0;
        nempty = 1'b0;
        for (int k = NEIGHBORS - 1; k >= 0; k--) begin
            if (r_naddr[k] == 16'd0) begin
                nempty = 1'b1;
            end
        end
        for (int k = NEIGHBORS - 1; k >= 0; k--) begin
            if (r_naddr[k] == r_na) begin
                nmatch = 1'b1;
            end
        end
        if (nmatch) begin
            for (int k = NEIGHBORS - 1; k >= 0; k--)
                if (r_naddr[k] == r_na) nslot = NW'(k);
        end else if (nempty) begin
            for (int k = NEIGHBORS - 1; k >= 0; k--)
                if (r_naddr[k] == 16'd0) nslot = NW'(k);
        end
    end

    logic new_direct;
    assign new_direct = (r_d == r_via) && (r_h == 8'd1);

    logic [7:0] hop_diff;
    assign hop_diff = r_hp[r_hit_idx] - r_h;

    logic rssi_take;
    assign rssi_take = (r_rs_new != 9'sh181) && (r_rs_old != 9'sh181)
                    && (r_rs_new >= r_rs_old + 9'sd10)
                    && (age_h > {8'd0, r_settle});

    logic lookup_hit;
    assign lookup_hit = (r_cmd == CMD_LOOKUP) && r_hit && (r_d != 16'd0) && !r_hit_exp;

    assign o_sts.last_idx   = (r_idx == LAST_R);
    assign o_sts.need_break = i_ctl.sweep_chk && (r_dest[r_idx] != 16'd0) && exp_i
                              && (r_hp[r_idx] != BROKEN_HOPS);
    assign o_sts.need_rssi  = (r_cmd == CMD_UPSERT) && (r_d != 16'd0) && r_hit && !exp_h
                              && (r_sqi == r_sq[r_hit_idx]) && (r_h == r_hp[r_hit_idx]);

    assign o_result = r_res;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbr_to <= 24'd10000;
            r_rte_to <= 24'd30000;
            r_settle <= 24'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NBR_TIMEOUT:   r_nbr_to <= i_cfg_data;
                CFG_ROUTE_TIMEOUT: r_rte_to <= i_cfg_data;
                CFG_SETTLE:        r_settle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // route and neighbor tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROUTES; k++) begin
                r_dest[k] <= '0; r_nh[k] <= '0; r_hp[k] <= '0;
                r_sq[k] <= '0; r_st[k] <= '0; r_mark[k] <= 1'b0;
            end
            for (int k = 0; k < NEIGHBORS; k++) begin
                r_naddr[k] <= '0;
                r_nrssi[k] <= RSSI_UNKNOWN;
            end
            r_victim     <= '0;
        end else begin
            if (i_ctl.commit) begin
                if (r_wk == W_FULL) begin
                    r_dest[r_wslot] <= r_d;   r_nh[r_wslot] <= r_via;
                    r_hp[r_wslot]   <= r_h;   r_sq[r_wslot] <= r_sqi;
                    r_st[r_wslot]   <= r_now; r_mark[r_wslot] <= 1'b1;
                end else if (r_wk == W_STAMP) begin
                    r_st[r_wslot] <= r_now;
                end else if (r_wk == W_RSSI) begin
                    if (rssi_take) begin
                        r_nh[r_wslot]   <= r_via;
                        r_st[r_wslot]   <= r_now; r_mark[r_wslot] <= 1'b1;
                    end else begin
                        r_st[r_wslot] <= r_now;
                    end
                end
            end
            if (i_ctl.sweep_chk && r_dest[r_idx] != 16'd0 && exp_i) begin
                if (r_hp[r_idx] != BROKEN_HOPS) begin
                    r_hp[r_idx]   <= BROKEN_HOPS;
                    if (!r_sq[r_idx][0]) r_sq[r_idx] <= r_sq[r_idx] + 32'd1;
                    r_mark[r_idx] <= 1'b1;
                    r_st[r_idx]   <= r_now;
                end else begin
                    r_dest[r_idx] <= '0; r_nh[r_idx] <= '0; r_hp[r_idx] <= '0;
                    r_sq[r_idx] <= '0; r_st[r_idx] <= '0; r_mark[r_idx] <= 1'b0;
                end
            end
            if (i_ctl.sweep_prop) begin
                for (int k = 0; k < ROUTES; k++) begin
                    if (r_dest[k] != 16'd0 && r_nh[k] == r_gone && r_hp[k] != BROKEN_HOPS) begin
                        r_hp[k]   <= BROKEN_HOPS;
                        r_st[k]   <= r_now;
                        r_mark[k] <= 1'b1;
                    end
                end
            end
            if (i_ctl.nbr_set && r_na != 16'd0) begin
                r_naddr[nslot] <= r_na;
                r_nrssi[nslot] <= r_rs;
                if (!nmatch && !nempty) begin
                    r_victim <= (r_victim == LAST_N) ? '0 : r_victim + NW'(1);
                end
            end
        end
    end

    // transaction datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd; r_now <= i_now_ms; r_d <= i_dest; r_via <= i_via_hop;
            r_h <= i_hops; r_sqi <= i_seq; r_na <= i_neighbor_addr; r_rs <= i_rssi;
            r_hit <= 1'b0; r_empty_ok <= 1'b0; r_hit_exp <= 1'b0;
            r_hit_idx <= '0; r_empty_idx <= '0; r_old_idx <= '0; r_best_age <= '0;
            r_oce <= 1'b0; r_rce <= 1'b0; r_wk <= W_NONE; r_wslot <= '0;
        end
        if (i_ctl.clr_idx) begin
            r_idx <= '0;
        end else if (i_ctl.inc_idx) begin
            r_idx <= r_idx + RW'(1);
        end
        if (i_ctl.scan_step) begin
            if (!r_hit && r_dest[r_idx] == r_d) begin
                r_hit <= 1'b1; r_hit_idx <= r_idx;
            end
            if (!r_empty_ok && r_dest[r_idx] == 16'd0) begin
                r_empty_ok <= 1'b1; r_empty_idx <= r_idx;
            end
            if (r_idx == '0 || age_i > r_best_age) begin
                r_best_age <= age_i; r_old_idx <= r_idx;
            end
        end
        if (i_ctl.decide) begin
            r_hit_exp <= exp_h;
            r_wslot   <= r_hit ? r_hit_idx : (r_empty_ok ? r_empty_idx : r_old_idx);
            if (r_cmd == CMD_UPSERT && r_d != 16'd0) begin
                if (!r_hit) begin
                    r_wk <= W_FULL; r_oce <= new_direct; r_rce <= 1'b1;
                end else if (exp_h || r_sqi > r_sq[r_hit_idx]) begin
                    r_wk <= W_FULL; r_oce <= new_direct; r_rce <= 1'b1;
                end else if (r_sqi == r_sq[r_hit_idx]) begin
                    if (r_h < r_hp[r_hit_idx]) begin
                        if (age_h > {8'd0, r_settle} || hop_diff >= HOP_JUMP) begin
                            r_wk <= W_FULL; r_rce <= 1'b1;
                        end else begin
                            r_wk <= W_STAMP;
                        end
                    end else if (r_h == r_hp[r_hit_idx]) begin
                        r_wk <= W_RSSI;
                    end
                end
            end
        end
        if (i_ctl.nbr_old) r_rs_old <= {nres[7], nres};
        if (i_ctl.nbr_new) r_rs_new <= {nres[7], nres};
        if (i_ctl.commit && r_wk == W_RSSI) r_rce <= rssi_take;
        if (i_ctl.sweep_chk && o_sts.need_break) begin
            r_gone <= r_dest[r_idx];
            r_rce  <= 1'b1;
            if (dir_i) r_oce <= 1'b1;
        end
        if (i_ctl.out_load) begin
            r_res <= {r_oce, r_rce, r_rce && (r_cmd == CMD_UPSERT),
                      lookup_hit ? {r_sq[r_hit_idx], r_hp[r_hit_idx], r_nh[r_hit_idx], 1'b1}
                                 : 57'd0};
        end
    end

endmodule

// File: rtl/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// DSDV route table with neighbor rssi table; one result per command.
//
// channel  dir  signals                       contents
// s_axis   in   s_axis_tvalid/tready/tdata    command transaction
// m_axis   out  m_axis_tvalid/tready/tdata    result transaction
// cfg      in   i_cfg_valid/o_cfg_ready       register index and data
//
// Lookup/upsert: serial slot scan (one slot/cycle), decide, optional rssi
// lookups, write. Sweep: serial check plus a step per broken route. Set rssi: one write.
// Reset clears all slots at once. A result waits in the output register;
// the next command is taken while it waits, until the next result is due.
// ----------------------------------------------------------------------------
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int ROUTES    = 16,
    parameter int NEIGHBORS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0] now_ms[33:2] dest[49:34] via_hop[65:50] hops[73:66]
    // seq[105:74] neighbor_addr[121:106] rssi[129:122]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found[0] out_next_hop[16:1] out_hops[24:17] out_seq[56:25] accepted[57]
    // route_changed_event[58] own_info_changed_event[59]
    output logic [63:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    t_ctl        ctl;
    t_sts        sts;
    logic        busy;
    logic [59:0] res;
    logic        r_valid;
    logic        out_free;

    assign out_free      = !r_valid || m_axis_tready;
    assign s_axis_tready = !busy;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {4'd0, res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    dvrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_axis_tvalid),
        .i_cmd      (s_axis_tdata[1:0]),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    dvrt_datapath #(
        .ROUTES    (ROUTES),
        .NEIGHBORS (NEIGHBORS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_idx       (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (s_axis_tdata[1:0]),
        .i_now_ms        (s_axis_tdata[33:2]),
        .i_dest          (s_axis_tdata[49:34]),
        .i_via_hop       (s_axis_tdata[65:50]),
        .i_hops          (s_axis_tdata[73:66]),
        .i_seq           (s_axis_tdata[105:74]),
        .i_neighbor_addr (s_axis_tdata[121:106]),
        .i_rssi          (s_axis_tdata[129:122]),
        .o_sts           (sts),
        .o_result        (res)
    );

endmodule
